[sv/acbd_pkg.sv]
// Shared types, constants and arithmetic helpers for the alpha composite and box decimation block.
`timescale 1ns / 1ps

package acbd_pkg;

    localparam int MAX_WIDTH_DEFAULT = 8192;
    localparam int MAX_HEIGHT        = 8192;
    localparam int ROW_W             = 13;
    localparam int DIM_W             = 14;
    localparam int CH_W              = 14;
    localparam int SUM_W             = 3 * CH_W;
    localparam int FIFO_DEPTH        = 8;
    localparam int PADDR_W           = 4;
    localparam int PDATA_W           = 32;

    localparam logic [1:0] REG_SOURCE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_DECIMATION_LOG2 = 2'd2;
    localparam logic [1:0] REG_BACKGROUND_RGB  = 2'd3;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } src_t;

    typedef struct packed {
        logic [15:0] pixel_565;
        logic        row_end;
        logic        frame_end;
    } res_t;

    typedef struct packed {
        logic active;
        logic start_h;
        logic box_end;
        logic start_band;
        logic fire;
        logic last_col;
        logic last_frame;
    } ctrl_t;

    function automatic logic [15:0] blend_num(input logic [7:0] c, input logic [7:0] a,
                                              input logic [7:0] bg);
        logic [15:0] fg_part;
        logic [15:0] bg_part;
        fg_part = {8'd0, c} * {8'd0, a};
        bg_part = {8'd0, bg} * {8'd0, 8'hFF - a};
        return fg_part + bg_part;
    endfunction

    // Exact floor(x / 255) for every x up to 65279, where the quotient still fits in eight bits.
    function automatic logic [7:0] blend_div(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [SUM_W-1:0] pack3(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return {CH_W'(r), CH_W'(g), CH_W'(b)};
    endfunction

    function automatic logic [SUM_W-1:0] add3(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] bl;
        r  = a[3*CH_W-1:2*CH_W] + b[3*CH_W-1:2*CH_W];
        g  = a[2*CH_W-1:CH_W] + b[2*CH_W-1:CH_W];
        bl = a[CH_W-1:0] + b[CH_W-1:0];
        return {r, g, bl};
    endfunction

    function automatic logic [7:0] avg_ch(input logic [CH_W-1:0] v, input logic [1:0] d);
        logic [CH_W-1:0] s;
        s = v >> {d, 1'b0};
        return (s > CH_W'(255)) ? 8'hFF : s[7:0];
    endfunction

endpackage

[sv/acbd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module acbd_ram #(
    parameter int WIDTH = acbd_pkg::SUM_W,
    parameter int DEPTH = acbd_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/alpha_composite_box_decimate_rgb565_core.sv]
// Top level: alpha composite, box decimation and RGB565 packing of an RGBA8888 pixel stream.
`timescale 1ns / 1ps

// The block takes one RGBA8888 source pixel per clock in raster order and produces one RGB565
// result per completed box, once the request that completes it has passed stages one to three. Each
// pixel is blended over the background colour, summed across its box row and then down the band
// through a line store of MAX_WIDTH entries of three 14-bit sums, which is read as each request
// is accepted and written from stage three, with recent writes forwarded. Results pass through an
// eight-entry queue, and src_stall rises only when that queue and the requests in flight would fill
// it, so a full rate of one pixel per clock holds whenever the result side keeps up. The line store
// needs no clearing after reset. Configuration is to be written only while the block is idle.

module alpha_composite_box_decimate_rgb565_core #(
    parameter int MAX_WIDTH = acbd_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acbd_pkg::PADDR_W-1:0]  paddr,
    input  logic [acbd_pkg::PDATA_W-1:0]  pwdata,
    output logic [acbd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  acbd_pkg::src_t                src_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output acbd_pkg::res_t                res_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int DW   = acbd_pkg::DIM_W;
    localparam int RW   = acbd_pkg::ROW_W;
    localparam int SW   = acbd_pkg::SUM_W;
    localparam int CHW  = acbd_pkg::CH_W;
    localparam int QD   = acbd_pkg::FIFO_DEPTH;
    localparam int QAW  = $clog2(QD);
    localparam int QCW  = $clog2(QD + 1);
    localparam int HIST = 3;

    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [1:0]    dlog_reg;
    logic [23:0]   bg_reg;

    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(1);
            height_reg <= DW'(1);
            dlog_reg   <= 2'd0;
            bg_reg     <= 24'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                acbd_pkg::REG_SOURCE_WIDTH:    width_reg  <= pwdata[DW-1:0];
                acbd_pkg::REG_SOURCE_HEIGHT:   height_reg <= pwdata[DW-1:0];
                acbd_pkg::REG_DECIMATION_LOG2: dlog_reg   <= pwdata[1:0];
                acbd_pkg::REG_BACKGROUND_RGB:  bg_reg     <= pwdata[23:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            acbd_pkg::REG_SOURCE_WIDTH:    prdata = 32'(width_reg);
            acbd_pkg::REG_SOURCE_HEIGHT:   prdata = 32'(height_reg);
            acbd_pkg::REG_DECIMATION_LOG2: prdata = 32'(dlog_reg);
            acbd_pkg::REG_BACKGROUND_RGB:  prdata = 32'(bg_reg);
            default:                       prdata = '0;
        endcase
    end

    // Frame geometry and position decode for the request at the input.
    logic [WW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [2:0]    dmask;
    logic [WW-1:0] w_act;
    logic [DW-1:0] h_act;
    logic [WW-1:0] ow;
    logic [DW-1:0] oh;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [WW-1:0] col_ext;
    logic [DW-1:0] row_ext;
    logic [CW-1:0] oc_now;
    logic [2:0]    colm;
    logic [2:0]    rowm;
    logic          src_accept;
    acbd_pkg::ctrl_t ctrl_now;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (width_reg > DW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = DW'(1);
        end
        else if (height_reg > DW'(acbd_pkg::MAX_HEIGHT))
        begin
            h_eff = DW'(acbd_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign dmask   = 3'((4'd1 << dlog_reg) - 4'd1);
    assign w_act   = w_eff & ~WW'(dmask);
    assign h_act   = h_eff & ~DW'(dmask);
    assign ow      = w_eff >> dlog_reg;
    assign oh      = h_eff >> dlog_reg;
    assign col_ext = WW'(col_reg);
    assign row_ext = DW'(row_reg);
    assign oc_now  = col_reg >> dlog_reg;
    assign colm    = col_reg[2:0] & dmask;
    assign rowm    = row_reg[2:0] & dmask;

    always_comb
    begin
        ctrl_now.active     = (col_ext < w_act) && (row_ext < h_act);
        ctrl_now.start_h    = (colm == 3'd0);
        ctrl_now.box_end    = ctrl_now.active && (colm == dmask);
        ctrl_now.start_band = (rowm == 3'd0);
        ctrl_now.fire       = ctrl_now.box_end && (rowm == dmask);
        ctrl_now.last_col   = (WW'(oc_now) == ow - WW'(1));
        ctrl_now.last_frame = ctrl_now.last_col
                              && (DW'(row_reg >> dlog_reg) == oh - DW'(1));
    end

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_ext + WW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + RW'(1);
            if (row_ext + DW'(1) >= h_eff)
            begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (src_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line store of per-column band sums.
    logic          ram_wr_en;
    logic [CW-1:0] ram_wr_addr;
    logic [SW-1:0] ram_wr_data;
    logic [SW-1:0] ram_rd_data;

    acbd_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_band_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (src_accept),
        .rd_addr (oc_now),
        .rd_data (ram_rd_data)
    );

    // Stage one: the accepted pixel and its position decode.
    logic            s1_valid_reg;
    acbd_pkg::ctrl_t s1_ctrl_reg;
    logic [CW-1:0]   s1_oc_reg;
    acbd_pkg::src_t  s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= src_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            s1_ctrl_reg <= ctrl_now;
            s1_oc_reg   <= oc_now;
            s1_pix_reg  <= src_data;
        end
    end

    // Stage two: blend numerators and the band entry read for this pixel.
    logic            s2_valid_reg;
    acbd_pkg::ctrl_t s2_ctrl_reg;
    logic [CW-1:0]   s2_oc_reg;
    logic [15:0]     s2_num_r_reg;
    logic [15:0]     s2_num_g_reg;
    logic [15:0]     s2_num_b_reg;
    logic [SW-1:0]   s2_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_ctrl_reg  <= s1_ctrl_reg;
        s2_oc_reg    <= s1_oc_reg;
        s2_band_reg  <= ram_rd_data;
        s2_num_r_reg <= acbd_pkg::blend_num(s1_pix_reg.red_in, s1_pix_reg.alpha_in,
                                            bg_reg[23:16]);
        s2_num_g_reg <= acbd_pkg::blend_num(s1_pix_reg.green_in, s1_pix_reg.alpha_in,
                                            bg_reg[15:8]);
        s2_num_b_reg <= acbd_pkg::blend_num(s1_pix_reg.blue_in, s1_pix_reg.alpha_in,
                                            bg_reg[7:0]);
    end

    // Blend result and the running sum across the current box row.
    logic [SW-1:0] px;
    logic [SW-1:0] hsum;
    logic [SW-1:0] pix_sum_reg;
    logic [SW-1:0] pix_sum_next;

    assign px   = acbd_pkg::pack3(acbd_pkg::blend_div(s2_num_r_reg),
                                  acbd_pkg::blend_div(s2_num_g_reg),
                                  acbd_pkg::blend_div(s2_num_b_reg));
    assign hsum = s2_ctrl_reg.start_h ? px : acbd_pkg::add3(pix_sum_reg, px);

    always_comb
    begin
        pix_sum_next = pix_sum_reg;
        if (s2_valid_reg && s2_ctrl_reg.active)
        begin
            pix_sum_next = s2_ctrl_reg.box_end ? '0 : hsum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_sum_reg <= '0;
        end
        else
        begin
            pix_sum_reg <= pix_sum_next;
        end
    end

    // Stage three: band accumulation, line store write and result packing.
    logic            s3_valid_reg;
    acbd_pkg::ctrl_t s3_ctrl_reg;
    logic [CW-1:0]   s3_oc_reg;
    logic [SW-1:0]   s3_acc_reg;
    logic [SW-1:0]   s3_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_ctrl_reg <= s2_ctrl_reg;
        s3_oc_reg   <= s2_oc_reg;
        s3_acc_reg  <= hsum;
        s3_band_reg <= s2_band_reg;
    end

    // The last three line store writes are kept, newest first, because the read for this
    // pixel was taken before they landed.
    logic          hist_valid_reg [HIST];
    logic [CW-1:0] hist_addr_reg  [HIST];
    logic [SW-1:0] hist_data_reg  [HIST];
    logic [SW-1:0] band_fwd;
    logic [SW-1:0] band_acc;
    logic          push;
    acbd_pkg::res_t push_data;
    logic [7:0]    avg_r;
    logic [7:0]    avg_g;
    logic [7:0]    avg_b;

    always_comb
    begin
        band_fwd = s3_band_reg;
        if (hist_valid_reg[2] && hist_addr_reg[2] == s3_oc_reg)
        begin
            band_fwd = hist_data_reg[2];
        end
        if (hist_valid_reg[1] && hist_addr_reg[1] == s3_oc_reg)
        begin
            band_fwd = hist_data_reg[1];
        end
        if (hist_valid_reg[0] && hist_addr_reg[0] == s3_oc_reg)
        begin
            band_fwd = hist_data_reg[0];
        end
    end

    assign band_acc    = s3_ctrl_reg.start_band ? s3_acc_reg
                                                : acbd_pkg::add3(band_fwd, s3_acc_reg);
    assign ram_wr_en   = s3_valid_reg && s3_ctrl_reg.box_end;
    assign ram_wr_addr = s3_oc_reg;
    assign ram_wr_data = band_acc;
    assign push        = s3_valid_reg && s3_ctrl_reg.fire;

    assign avg_r = acbd_pkg::avg_ch(band_acc[3*CHW-1:2*CHW], dlog_reg);
    assign avg_g = acbd_pkg::avg_ch(band_acc[2*CHW-1:CHW], dlog_reg);
    assign avg_b = acbd_pkg::avg_ch(band_acc[CHW-1:0], dlog_reg);

    always_comb
    begin
        push_data.pixel_565 = {avg_r[7:3], avg_g[7:2], avg_b[7:3]};
        push_data.row_end   = s3_ctrl_reg.last_col;
        push_data.frame_end = s3_ctrl_reg.last_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST; i++)
            begin
                hist_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            hist_valid_reg[0] <= ram_wr_en;
            for (int i = 1; i < HIST; i++)
            begin
                hist_valid_reg[i] <= hist_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hist_addr_reg[0] <= ram_wr_addr;
        hist_data_reg[0] <= ram_wr_data;
        for (int i = 1; i < HIST; i++)
        begin
            hist_addr_reg[i] <= hist_addr_reg[i-1];
            hist_data_reg[i] <= hist_data_reg[i-1];
        end
    end

    // Result queue; input requests are held off while it could overflow.
    acbd_pkg::res_t q_mem [QD];
    logic [QAW-1:0] q_wr_ptr_reg;
    logic [QAW-1:0] q_rd_ptr_reg;
    logic [QCW-1:0] q_count_reg;
    logic [QCW:0]   pending;
    logic           pop;

    assign res_valid = (q_count_reg != '0);
    assign res_data  = q_mem[q_rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    assign pending = (QCW+1)'(q_count_reg)
                     + (QCW+1)'(s1_valid_reg && s1_ctrl_reg.fire)
                     + (QCW+1)'(s2_valid_reg && s2_ctrl_reg.fire)
                     + (QCW+1)'(s3_valid_reg && s3_ctrl_reg.fire);
    assign src_stall  = (pending >= (QCW+1)'(QD));
    assign src_accept = src_valid && !src_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[q_wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                q_wr_ptr_reg <= q_wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                q_rd_ptr_reg <= q_rd_ptr_reg + QAW'(1);
            end
            if (push && !pop)
            begin
                q_count_reg <= q_count_reg + QCW'(1);
            end
            else if (pop && !push)
            begin
                q_count_reg <= q_count_reg - QCW'(1);
            end
        end
    end

endmodule

[sv/acbd_checker.sv]
// Port-level checks for the alpha composite and box decimation block, bound to its top level.
`timescale 1ns / 1ps

module acbd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           src_valid,
    input logic           src_stall,
    input logic           res_valid,
    input logic           res_stall,
    input acbd_pkg::res_t res_data
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result request changed or was withdrawn");

    // The end of a frame is always the end of a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.frame_end |-> res_data.row_end)
    else $error("frame end flagged on a result that is not a row end");

    // An empty result side only fills with the outcome of an earlier accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(src_valid && !src_stall, 4))
    else $error("result appeared without a matching accepted request");

endmodule

bind alpha_composite_box_decimate_rgb565_core acbd_checker u_acbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
